/* rtl/scaled_legendre_value_and_slope_defines.svh */
// Assertion macros for the scaled Legendre value and slope block.
`ifndef SCALED_LEGENDRE_VALUE_AND_SLOPE_DEFINES_SVH
`define SCALED_LEGENDRE_VALUE_AND_SLOPE_DEFINES_SVH

// same-cycle implication
`define SLVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slvs_pkg.sv */
// Shared types, widths, constants and helpers of the scaled Legendre block.
package slvs_pkg;

  localparam int MAX_ORDER_DEF = 8;

  localparam int POS_W  = 18;
  localparam int ORD_W  = 4;
  localparam int RES_W  = 48;
  localparam int FRAC   = 24;
  localparam int Y_SH   = 9;
  localparam int MUL_SH = FRAC - Y_SH;
  localparam int P_W    = 43;
  localparam int FULL_W = 67;
  localparam int M_W    = 51;
  localparam int NUM_W  = 57;
  localparam int DIV_W  = NUM_W - 1;
  localparam int DL_W   = DIV_W / 2;
  localparam int DH_W   = DIV_W - DL_W;
  localparam int REM_W  = 4;
  localparam int VL_W   = DL_W + REM_W;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 2 * RES_W;

  localparam logic signed [RES_W-1:0] ONE_Q24 =
    {{(RES_W - FRAC - 1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};
  localparam logic signed [FULL_W-1:0] RND_C = FULL_W'(2 ** (MUL_SH - 1));

  typedef struct packed {
    logic                    sat;
    logic signed [RES_W-1:0] d_cur;
    logic signed [RES_W-1:0] p_cur;
    logic signed [RES_W-1:0] p_prev;
    logic [ORD_W-1:0]        order;
    logic signed [POS_W-1:0] x;
  } slvs_link_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_ADD,
    CS_NUM,
    CS_DIV,
    CS_REM,
    CS_LOW,
    CS_DONE
  } slvs_cst_t;

  function automatic logic signed [RES_W-1:0] scale_pos(input logic signed [POS_W-1:0] x);
    return RES_W'(x) <<< Y_SH;
  endfunction

  // combine the two partial products of x * b into round(2x * b) in Q.24
  function automatic logic signed [M_W-1:0] q24_fold(input logic signed [P_W-1:0] hi,
                                                     input logic signed [P_W-1:0] lo);
    logic signed [FULL_W-1:0] full;
    full = (FULL_W'(hi) <<< FRAC) + FULL_W'(lo) + RND_C;
    return M_W'(full >>> MUL_SH);
  endfunction

  function automatic logic over_res(input logic signed [NUM_W-1:0] v);
    return (v > NUM_W'(RES_MAX)) || (v < NUM_W'(RES_MIN));
  endfunction

  function automatic logic signed [RES_W-1:0] clip_res(input logic signed [NUM_W-1:0] v);
    if (v > NUM_W'(RES_MAX)) begin
      return RES_MAX;
    end else if (v < NUM_W'(RES_MIN)) begin
      return RES_MIN;
    end
    return RES_W'(v);
  endfunction

endpackage

/* rtl/slvs_cell.sv */
// One recurrence cell: step K of the value and slope recurrences.
module slvs_cell
  import slvs_pkg::*;
#(
  parameter int K = 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  slvs_link_t up_link,
  output logic       dn_valid,
  input  logic       dn_ready,
  output slvs_link_t dn_link
);

  localparam logic signed [NUM_W-1:0] ODD_C = NUM_W'(2 * K + 1);
  localparam logic signed [NUM_W-1:0] K_C   = NUM_W'(K);
  localparam logic signed [NUM_W-1:0] K1_C  = NUM_W'(K + 1);
  localparam logic [DIV_W-1:0] HALF_C = DIV_W'((K + 1) / 2);
  localparam logic [ORD_W-1:0] K_ORD  = ORD_W'(K);
  localparam int L_SH = $clog2(K + 1);
  localparam int SH_H = DH_W + L_SH;
  localparam int SH_L = VL_W + L_SH;
  localparam logic [DH_W:0] RCP_H = (DH_W + 1)'(((longint'(1) <<< SH_H) + K) / (K + 1));
  localparam logic [VL_W:0] RCP_L = (VL_W + 1)'(((longint'(1) <<< SH_L) + K) / (K + 1));
  localparam logic [DH_W-1:0] DIV_H = DH_W'(K + 1);

  slvs_cst_t st_r, st_nxt;

  slvs_link_t lnk_r;
  logic act_r;
  logic act_nxt;
  logic signed [P_W-1:0] pph_r, ppl_r, pdh_r, pdl_r;
  logic signed [M_W-1:0] m_r, md_r;
  logic neg_r;
  logic signed [RES_W-1:0] dnew_r;
  logic dsat_r;
  logic [DIV_W-1:0] quo_r;
  logic [DH_W-1:0] qh_r, qh_nxt, rh_full;
  logic [VL_W-1:0] v_r;
  logic [DL_W-1:0] ql_nxt;
  logic [2*DH_W:0] prod_h;
  logic [2*VL_W:0] prod_l;

  logic signed [NUM_W-1:0] num_nxt, mag_nxt, dsum_nxt, pval;

  assign act_nxt = K_ORD < up_link.order;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    up_ready = 1'b0;
    dn_valid = 1'b0;
    case (st_r)
      CS_IDLE: begin
        up_ready = 1'b1;
        if (up_valid) begin
          st_nxt = act_nxt ? CS_MUL : CS_DONE;
        end
      end
      CS_MUL: st_nxt = CS_ADD;
      CS_ADD: st_nxt = CS_NUM;
      CS_NUM: st_nxt = CS_DIV;
      CS_DIV: st_nxt = CS_REM;
      CS_REM: st_nxt = CS_LOW;
      CS_LOW: st_nxt = CS_DONE;
      CS_DONE: begin
        dn_valid = 1'b1;
        if (dn_ready) begin
          st_nxt = CS_IDLE;
        end
      end
      default: st_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    num_nxt  = NUM_W'(m_r) * ODD_C - NUM_W'(lnk_r.p_prev) * K_C;
    mag_nxt  = num_nxt[NUM_W-1] ? -num_nxt : num_nxt;
    dsum_nxt = NUM_W'(lnk_r.p_cur) * K1_C + NUM_W'(md_r);
  end

  // divide by K+1: reciprocal multiply on the upper half, then on remainder and lower half
  always_comb begin
    prod_h  = {{(DH_W + 1){1'b0}}, quo_r[DIV_W-1:DL_W]} * {{DH_W{1'b0}}, RCP_H};
    qh_nxt  = DH_W'(prod_h >> SH_H);
    rh_full = quo_r[DIV_W-1:DL_W] - qh_r * DIV_H;
    prod_l  = {{(VL_W + 1){1'b0}}, v_r} * {{VL_W{1'b0}}, RCP_L};
    ql_nxt  = DL_W'(prod_l >> SH_L);
  end

  always_ff @(posedge clk) begin
    case (st_r)
      CS_IDLE: begin
        if (up_valid) begin
          lnk_r <= up_link;
          act_r <= act_nxt;
        end
      end
      CS_MUL: begin
        pph_r <= P_W'($signed(lnk_r.x) * $signed(lnk_r.p_cur[RES_W-1:FRAC]));
        ppl_r <= P_W'($signed(lnk_r.x) * $signed({1'b0, lnk_r.p_cur[FRAC-1:0]}));
        pdh_r <= P_W'($signed(lnk_r.x) * $signed(lnk_r.d_cur[RES_W-1:FRAC]));
        pdl_r <= P_W'($signed(lnk_r.x) * $signed({1'b0, lnk_r.d_cur[FRAC-1:0]}));
      end
      CS_ADD: begin
        m_r  <= q24_fold(pph_r, ppl_r);
        md_r <= q24_fold(pdh_r, pdl_r);
      end
      CS_NUM: begin
        neg_r  <= num_nxt[NUM_W-1];
        quo_r  <= DIV_W'(mag_nxt) + HALF_C;
        dnew_r <= clip_res(dsum_nxt);
        dsat_r <= over_res(dsum_nxt);
      end
      CS_DIV: begin
        qh_r <= qh_nxt;
      end
      CS_REM: begin
        v_r <= {rh_full[REM_W-1:0], quo_r[DL_W-1:0]};
      end
      CS_LOW: begin
        quo_r <= {qh_r, ql_nxt};
      end
      default: ;
    endcase
  end

  always_comb begin
    pval    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    dn_link = lnk_r;
    if (act_r) begin
      dn_link.p_prev = lnk_r.p_cur;
      dn_link.p_cur  = clip_res(pval);
      dn_link.d_cur  = dnew_r;
      dn_link.sat    = lnk_r.sat | dsat_r | over_res(pval);
    end
  end

endmodule

/* rtl/scaled_legendre_value_and_slope.sv */
// Top level: Legendre value and slope at y = 2x through a chain of recurrence cells.
//
//   port group | dir | payload (low bit first)
//   in_*       | in  | tdata: position[17:0], poly_order[21:18], zero pad
//   out_*      | out | tdata: poly_value[47:0], poly_slope[95:48]; tuser: saturated
//
// Cell k (k = 1 .. MAX_ORDER-1) works on an item only when k < order: it then
// steps through MUL, ADD and NUM and divides by k+1 in DIV, REM and LOW;
// otherwise it passes the item straight on through DONE. It takes its next
// item in the cycle after handing one on.
// Up to MAX_ORDER items are in flight: one per cell and one in the output register.
// Synchronous active-low reset empties every cell and the output register.
// A stalled output holds the result; the chain backs up cell by cell.
`include "scaled_legendre_value_and_slope_defines.svh"

module scaled_legendre_value_and_slope
  import slvs_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // position, poly_order, pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // poly_value, poly_slope
  output logic [0:0]       out_tuser   // saturated
);

  localparam int NCELL = MAX_ORDER - 1;

  slvs_link_t lnk [NCELL+1];
  logic [NCELL:0] vld, rdy;

  logic [ORD_W-1:0] ord_in;
  logic out_ld;

  logic out_valid_r;
  logic signed [RES_W-1:0] value_r, slope_r;
  logic sat_r;

  slvs_link_t tail;
  logic ord0_ok, ord1_ok;

  always_comb begin
    ord_in = in_tdata[POS_W+ORD_W-1:POS_W];
    if (32'(ord_in) > MAX_ORDER) begin
      ord_in = ORD_W'(MAX_ORDER);
    end
    lnk[0].x     = $signed(in_tdata[POS_W-1:0]);
    lnk[0].order = ord_in;
    lnk[0].sat   = 1'b0;
    lnk[0].p_prev = ONE_Q24;
    if (ord_in == '0) begin
      lnk[0].p_cur = ONE_Q24;
      lnk[0].d_cur = '0;
    end else begin
      lnk[0].p_cur = scale_pos($signed(in_tdata[POS_W-1:0]));
      lnk[0].d_cur = ONE_Q24;
    end
  end

  assign vld[0]    = in_tvalid;
  assign in_tready = rdy[0];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    slvs_cell #(
      .K(g + 1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(vld[g]),
      .up_ready(rdy[g]),
      .up_link (lnk[g]),
      .dn_valid(vld[g+1]),
      .dn_ready(rdy[g+1]),
      .dn_link (lnk[g+1])
    );
  end

  assign rdy[NCELL] = !out_valid_r || out_tready;
  assign out_ld     = vld[NCELL] && rdy[NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      value_r <= lnk[NCELL].p_cur;
      slope_r <= lnk[NCELL].d_cur;
      sat_r   <= lnk[NCELL].sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {slope_r, value_r};
  assign out_tuser  = sat_r;

  assign tail    = lnk[NCELL];
  assign ord0_ok = tail.p_cur == ONE_Q24 && tail.d_cur == '0 && !tail.sat;
  assign ord1_ok = tail.p_cur == scale_pos(tail.x) && tail.d_cur == ONE_Q24 && !tail.sat;

  `SLVS_ASSERT_NOW(a_order_zero, out_ld && tail.order == '0, ord0_ok, "order zero item altered")
  `SLVS_ASSERT_NOW(a_order_one, out_ld && tail.order == ORD_W'(1), ord1_ok, "order one item altered")
  `SLVS_ASSERT_NEXT(a_out_load, out_ld, out_tvalid && out_tuser[0] == $past(tail.sat), "result not held")

endmodule
